@@ rtl/mesc_pkg.sv @@
// Shared types, constants and codes for the mesh element size and center block.
package mesc_pkg;

  localparam int COORD_BITS_DEF         = 24;
  localparam int ELEMENT_COUNT_BITS_DEF = 20;

  localparam int MAX_CORNERS  = 4;
  localparam int CORNER_IDX_W = 2;

  localparam logic [2:0] COUNTER_SAT  = 3'd7;
  localparam logic [2:0] TRI_CORNERS  = 3'd3;
  localparam logic [2:0] QUAD_CORNERS = 3'd4;

  localparam int FIELD_W = 24;
  localparam int SIZE_W  = 52;
  localparam int AVG_W   = 26;

  typedef struct packed {
    logic signed [FIELD_W-1:0] corner_x;
    logic signed [FIELD_W-1:0] corner_y;
    logic signed [FIELD_W-1:0] corner_z;
    logic                      element_end;
    logic                      mesh_end;
  } mesc_in_t;

  typedef struct packed {
    logic [SIZE_W-1:0]         size_squared;
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] center_z;
    logic                      corner_count_error;
    logic                      average_valid;
    logic [AVG_W-1:0]          average_size;
  } mesc_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_DIFF,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_CEN_SUM,
    ST_CEN_MAG,
    ST_CEN_MUL,
    ST_CEN_FIN,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } mesc_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_SQ_DIFF,
    OP_MUL,
    OP_SQ_ACC,
    OP_CEN_SUM,
    OP_CEN_MAG,
    OP_CEN_FIN,
    OP_ROOT_GO,
    OP_ACCUM,
    OP_DIV_GO,
    OP_LOAD
  } mesc_op_t;

  typedef enum logic [2:0] {
    PAIR_1_0,
    PAIR_2_1,
    PAIR_0_2,
    PAIR_2_0,
    PAIR_3_1
  } mesc_pair_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } mesc_axis_t;

  typedef struct packed {
    mesc_op_t   op;
    mesc_pair_t pair;
    mesc_axis_t axis;
  } mesc_cmd_t;

  typedef struct packed {
    logic item_end;
    logic elem_ok;
    logic quad;
    logic mesh;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } mesc_status_t;

endpackage

@@ rtl/mesc_isqrt.sv @@
// Iterative integer square root, one result bit per clock cycle.
module mesc_isqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   value,
  output logic              busy,
  output logic [IN_W/2-1:0] root
);

  logic [IN_W-1:0] rem;
  logic [IN_W-1:0] res;
  logic [IN_W-1:0] bitv;
  logic [IN_W:0]   trial;
  logic            take;

  always_comb begin
    trial = {1'b0, res} + {1'b0, bitv};
    take  = ({1'b0, rem} >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= {2'b01, {(IN_W-2){1'b0}}};
    end else if (busy) begin
      if (take) begin
        rem <= rem - trial[IN_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[IN_W/2-1:0];

endmodule

@@ rtl/mesc_divider.sv @@
// Restoring unsigned divider, one quotient bit per clock cycle.
module mesc_divider #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= denom;
      rem <= '0;
      quo <= numer;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/mesc_datapath.sv @@
// Datapath: corner store, shared multiplier, size and centroid registers, mean accumulators.
module mesc_datapath
  import mesc_pkg::*;
#(
  parameter int COORD_BITS         = COORD_BITS_DEF,
  parameter int ELEMENT_COUNT_BITS = ELEMENT_COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  mesc_cmd_t    cmd,
  output mesc_status_t status,
  input  mesc_in_t     corner,
  output logic         result_valid,
  input  logic         result_ready,
  output mesc_out_t    result
);

  localparam int OP_W        = COORD_BITS + 2;
  localparam int SQ_W        = 2 * COORD_BITS + 2;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int CNT_W       = ELEMENT_COUNT_BITS + 1;
  localparam int SUM_W       = ROOT_W + ELEMENT_COUNT_BITS;
  localparam int RECIP_SHIFT = OP_W + 1;
  localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
  localparam logic [OP_W-1:0] RECIP = OP_W'(RECIP_FULL);

  logic signed [COORD_BITS-1:0] stored_x [MAX_CORNERS];
  logic signed [COORD_BITS-1:0] stored_y [MAX_CORNERS];
  logic signed [COORD_BITS-1:0] stored_z [MAX_CORNERS];
  logic [COORD_BITS-1:0]        axis_coord [MAX_CORNERS];

  logic [2:0]              corner_counter;
  logic [2:0]              counter_inc;
  logic [2:0]              corner_total;
  logic                    mesh_flag;
  logic                    elem_ok;
  logic                    quad;
  logic                    item_end;

  logic [COORD_BITS-1:0]   pair_a;
  logic [COORD_BITS-1:0]   pair_b;
  logic [COORD_BITS:0]     diff;
  logic [COORD_BITS:0]     diff_neg;
  logic [COORD_BITS-1:0]   diff_mag;

  logic [OP_W-1:0]         mul_a;
  logic [OP_W-1:0]         mul_b;
  logic [2*OP_W-1:0]       product;

  logic [SQ_W-1:0]         dist_acc;
  logic [SQ_W-1:0]         dist_sum;
  logic [SQ_W-1:0]         size_max;

  logic [OP_W-1:0]         center_total;
  logic [OP_W-1:0]         center_sum;
  logic [OP_W-1:0]         center_mag;
  logic                    center_neg;
  logic [OP_W-1:0]         q_mag;
  logic [OP_W-1:0]         q_signed;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;

  logic [SUM_W-1:0]        size_root_sum;
  logic [CNT_W-1:0]        element_counter;

  logic                    root_busy;
  logic [ROOT_W-1:0]       root_value;
  logic                    div_busy;
  logic [SUM_W-1:0]        quotient;
  logic                    out_free;
  mesc_out_t               result_next;

  function automatic logic [OP_W-1:0] ext_coord(input logic [COORD_BITS-1:0] c);
    return {{2{c[COORD_BITS-1]}}, c};
  endfunction

  assign item_end    = corner.element_end | corner.mesh_end;
  assign elem_ok     = (corner_total == TRI_CORNERS) || (corner_total == QUAD_CORNERS);
  assign quad        = (corner_total == QUAD_CORNERS);
  assign out_free    = !result_valid || result_ready;
  assign counter_inc = (corner_counter < COUNTER_SAT) ? corner_counter + 3'd1 : corner_counter;

  always_comb begin
    for (int i = 0; i < MAX_CORNERS; i++) begin
      case (cmd.axis)
        AXIS_Y:  axis_coord[i] = stored_y[i];
        AXIS_Z:  axis_coord[i] = stored_z[i];
        default: axis_coord[i] = stored_x[i];
      endcase
    end
  end

  always_comb begin
    case (cmd.pair)
      PAIR_1_0: begin
        pair_a = axis_coord[1];
        pair_b = axis_coord[0];
      end
      PAIR_2_1: begin
        pair_a = axis_coord[2];
        pair_b = axis_coord[1];
      end
      PAIR_0_2: begin
        pair_a = axis_coord[0];
        pair_b = axis_coord[2];
      end
      PAIR_2_0: begin
        pair_a = axis_coord[2];
        pair_b = axis_coord[0];
      end
      default: begin
        pair_a = axis_coord[3];
        pair_b = axis_coord[1];
      end
    endcase
  end

  always_comb begin
    diff     = {pair_a[COORD_BITS-1], pair_a} - {pair_b[COORD_BITS-1], pair_b};
    diff_neg = -diff;
    diff_mag = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
    dist_sum = dist_acc + SQ_W'(product);
    center_total = ext_coord(axis_coord[0]) + ext_coord(axis_coord[1])
                 + ext_coord(axis_coord[2]) + (quad ? ext_coord(axis_coord[3]) : '0);
    center_mag = center_sum[OP_W-1] ? -center_sum : center_sum;
    q_mag      = quad ? (mul_a >> 2) : OP_W'(product >> RECIP_SHIFT);
    q_signed   = center_neg ? -q_mag : q_mag;
  end

  always_comb begin
    result_next = '0;
    result_next.corner_count_error = !elem_ok;
    result_next.average_valid      = mesh_flag;
    if (elem_ok) begin
      result_next.size_squared = SIZE_W'(size_max);
      result_next.center_x     = FIELD_W'(center_x);
      result_next.center_y     = FIELD_W'(center_y);
      result_next.center_z     = FIELD_W'(center_z);
    end
    if (mesh_flag && (element_counter != '0)) begin
      result_next.average_size = AVG_W'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_counter  <= '0;
      size_root_sum   <= '0;
      element_counter <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cmd.op == OP_STORE) begin
        corner_counter <= item_end ? 3'd0 : counter_inc;
      end
      if ((cmd.op == OP_ACCUM) && elem_ok && !element_counter[ELEMENT_COUNT_BITS]) begin
        size_root_sum   <= size_root_sum + SUM_W'(root_value);
        element_counter <= element_counter + 1'b1;
      end
      if (cmd.op == OP_LOAD) begin
        result_valid <= 1'b1;
        if (mesh_flag) begin
          size_root_sum   <= '0;
          element_counter <= '0;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE: begin
        if (corner_counter < 3'(MAX_CORNERS)) begin
          stored_x[corner_counter[CORNER_IDX_W-1:0]] <= corner.corner_x[COORD_BITS-1:0];
          stored_y[corner_counter[CORNER_IDX_W-1:0]] <= corner.corner_y[COORD_BITS-1:0];
          stored_z[corner_counter[CORNER_IDX_W-1:0]] <= corner.corner_z[COORD_BITS-1:0];
        end
        if (item_end) begin
          corner_total <= counter_inc;
          mesh_flag    <= corner.mesh_end;
          dist_acc     <= '0;
          size_max     <= '0;
        end
      end
      OP_SQ_DIFF: begin
        mul_a <= OP_W'(diff_mag);
        mul_b <= OP_W'(diff_mag);
      end
      OP_MUL: begin
        product <= mul_a * mul_b;
      end
      OP_SQ_ACC: begin
        if (cmd.axis == AXIS_Z) begin
          dist_acc <= '0;
          if (dist_sum > size_max) begin
            size_max <= dist_sum;
          end
        end else begin
          dist_acc <= dist_sum;
        end
      end
      OP_CEN_SUM: begin
        center_sum <= center_total;
      end
      OP_CEN_MAG: begin
        center_neg <= center_sum[OP_W-1];
        mul_a      <= center_mag;
        mul_b      <= RECIP;
      end
      OP_CEN_FIN: begin
        case (cmd.axis)
          AXIS_Y:  center_y <= q_signed[COORD_BITS-1:0];
          AXIS_Z:  center_z <= q_signed[COORD_BITS-1:0];
          default: center_x <= q_signed[COORD_BITS-1:0];
        endcase
      end
      OP_LOAD: begin
        result <= result_next;
      end
      default: begin
      end
    endcase
  end

  mesc_isqrt #(
    .IN_W(SQ_W)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_ROOT_GO),
    .value (size_max),
    .busy  (root_busy),
    .root  (root_value)
  );

  mesc_divider #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_GO),
    .numer    (size_root_sum),
    .denom    (element_counter),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    status.item_end  = item_end;
    status.elem_ok   = elem_ok;
    status.quad      = quad;
    status.mesh      = mesh_flag;
    status.root_busy = root_busy;
    status.div_busy  = div_busy;
    status.out_free  = out_free;
  end

endmodule

@@ rtl/mesc_ctrl.sv @@
// Controller state machine that sequences the datapath for each ended element.
module mesc_ctrl
  import mesc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         corner_valid,
  output logic         corner_ready,
  input  mesc_status_t status,
  output mesc_cmd_t    cmd
);

  mesc_state_t state;
  mesc_state_t state_next;
  logic [1:0]  pair_idx;
  logic [1:0]  pair_idx_next;
  mesc_axis_t  axis;
  mesc_axis_t  axis_next;
  mesc_axis_t  axis_inc;
  mesc_pair_t  pair_code;
  logic        pair_last;

  always_comb begin
    case (axis)
      AXIS_X:  axis_inc = AXIS_Y;
      AXIS_Y:  axis_inc = AXIS_Z;
      default: axis_inc = AXIS_X;
    endcase
  end

  always_comb begin
    if (status.quad) begin
      pair_code = (pair_idx == 2'd0) ? PAIR_2_0 : PAIR_3_1;
      pair_last = (pair_idx == 2'd1);
    end else begin
      case (pair_idx)
        2'd0:    pair_code = PAIR_1_0;
        2'd1:    pair_code = PAIR_2_1;
        default: pair_code = PAIR_0_2;
      endcase
      pair_last = (pair_idx == 2'd2);
    end
  end

  always_comb begin
    state_next    = state;
    pair_idx_next = pair_idx;
    axis_next     = axis;
    case (state)
      ST_IDLE: begin
        if (corner_valid && status.item_end) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        pair_idx_next = 2'd0;
        axis_next     = AXIS_X;
        state_next    = status.elem_ok ? ST_SQ_DIFF : ST_ACCUM;
      end
      ST_SQ_DIFF: state_next = ST_SQ_MUL;
      ST_SQ_MUL:  state_next = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (axis != AXIS_Z) begin
          axis_next  = axis_inc;
          state_next = ST_SQ_DIFF;
        end else begin
          axis_next = AXIS_X;
          if (pair_last) begin
            state_next = ST_CEN_SUM;
          end else begin
            pair_idx_next = pair_idx + 2'd1;
            state_next    = ST_SQ_DIFF;
          end
        end
      end
      ST_CEN_SUM: state_next = ST_CEN_MAG;
      ST_CEN_MAG: state_next = ST_CEN_MUL;
      ST_CEN_MUL: state_next = ST_CEN_FIN;
      ST_CEN_FIN: begin
        if (axis != AXIS_Z) begin
          axis_next  = axis_inc;
          state_next = ST_CEN_SUM;
        end else begin
          state_next = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (!status.root_busy) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: state_next = status.mesh ? ST_DIV_GO : ST_OUT;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    corner_ready = 1'b0;
    cmd.op       = OP_NONE;
    cmd.pair     = pair_code;
    cmd.axis     = axis;
    case (state)
      ST_IDLE: begin
        corner_ready = 1'b1;
        if (corner_valid) begin
          cmd.op = OP_STORE;
        end
      end
      ST_SQ_DIFF: cmd.op = OP_SQ_DIFF;
      ST_SQ_MUL:  cmd.op = OP_MUL;
      ST_SQ_ACC:  cmd.op = OP_SQ_ACC;
      ST_CEN_SUM: cmd.op = OP_CEN_SUM;
      ST_CEN_MAG: cmd.op = OP_CEN_MAG;
      ST_CEN_MUL: cmd.op = OP_MUL;
      ST_CEN_FIN: cmd.op = OP_CEN_FIN;
      ST_ROOT_GO: cmd.op = OP_ROOT_GO;
      ST_ACCUM:   cmd.op = OP_ACCUM;
      ST_DIV_GO:  cmd.op = OP_DIV_GO;
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_LOAD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pair_idx <= 2'd0;
      axis     <= AXIS_X;
    end else begin
      state    <= state_next;
      pair_idx <= pair_idx_next;
      axis     <= axis_next;
    end
  end

endmodule

@@ rtl/mesh_element_size_and_center_core.sv @@
// Top level of the mesh element size and center block. Corners arrive one per transfer
// and are stored as they are taken; a corner that ends an element holds off the next
// transfer while the controller runs the shared multiplier over the squared edges or
// diagonals and the three centroid divisions, then the bit-serial square root. An element
// with a bad corner count skips these steps. The corner that ends the mesh adds the mean
// division, one bit per cycle. A finished result waits in the output register, so the
// next corner transfer can be taken before the result is taken.
module mesh_element_size_and_center_core
  import mesc_pkg::*;
#(
  parameter int COORD_BITS         = COORD_BITS_DEF,
  parameter int ELEMENT_COUNT_BITS = ELEMENT_COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      corner_valid,
  output logic      corner_ready,
  input  mesc_in_t  corner,
  output logic      result_valid,
  input  logic      result_ready,
  output mesc_out_t result
);

  mesc_cmd_t    cmd;
  mesc_status_t status;

  mesc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .status       (status),
    .cmd          (cmd)
  );

  mesc_datapath #(
    .COORD_BITS        (COORD_BITS),
    .ELEMENT_COUNT_BITS(ELEMENT_COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .corner       (corner),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
